/* sv/gem_pkg.sv */
// Package for the gradient edge magnitude block.
// Holds sizes, register and mode codes, the controller state type and the root unit status.
// No dependencies.
`default_nettype none

package gem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = COL_W + 1;
    localparam int HEI_W  = ROW_W + 1;
    localparam int GRAD_W = 11;
    localparam int SUM_W  = 21;
    localparam int ROOT_BIT_W = $clog2(PIX_W);

    localparam logic [WID_W-1:0] MIN_DIM_W   = WID_W'(3);
    localparam logic [HEI_W-1:0] MIN_DIM_H   = HEI_W'(3);
    localparam logic [WID_W-1:0] MAX_WID_VAL = WID_W'(MAX_WIDTH);
    localparam logic [HEI_W-1:0] MAX_HEI_VAL = HEI_W'(MAX_HEIGHT);

    localparam logic [1:0] MODE_ROBERTS = 2'd0;
    localparam logic [1:0] MODE_PREWITT = 2'd1;
    localparam logic [1:0] MODE_SOBEL   = 2'd2;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [1:0]       MODE_RESET   = MODE_SOBEL;
    localparam logic [10:0]      WIDTH_RESET  = 11'd640;
    localparam logic [12:0]      HEIGHT_RESET = 13'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQR,
        ST_ROOT,
        ST_OUT
    } gem_state_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] value;
    } root_stat_t;

endpackage

`default_nettype wire

/* sv/gem_root.sv */
// Bit-serial rounded square root, saturated to 8 bits.
// Finds the largest n with n*(n-1) < sum, one result bit per cycle.
// Depends on gem_pkg.
`default_nettype none

module gem_root
    import gem_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] sum,
    output root_stat_t            stat
);

    logic                  active_reg, active_next;
    logic [ROOT_BIT_W-1:0] bit_reg, bit_next;
    logic [PIX_W-1:0]      n_reg, n_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [PIX_W-1:0]      trial;
    logic [2*PIX_W-1:0]    prod;

    always_comb
    begin
        trial       = n_reg | (PIX_W'(1) << bit_reg);
        prod        = trial * (trial - PIX_W'(1));
        active_next = active_reg;
        bit_next    = bit_reg;
        n_next      = n_reg;
        sum_next    = sum_reg;
        if (start)
        begin
            active_next = 1'b1;
            bit_next    = ROOT_BIT_W'(PIX_W - 1);
            n_next      = '0;
            sum_next    = sum;
        end
        else if (active_reg)
        begin
            // keep the trial bit while the trial still lies below the sum
            if (SUM_W'(prod) < sum_reg)
            begin
                n_next = trial;
            end
            bit_next = bit_reg - ROOT_BIT_W'(1);
            if (bit_reg == '0)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            bit_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            bit_reg    <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        sum_reg <= sum_next;
    end

    assign stat.done  = active_reg && (bit_reg == '0);
    assign stat.value = n_reg;

endmodule

`default_nettype wire

/* sv/gradient_edge_magnitude_top.sv */
// Top level of the gradient edge magnitude block: stream ports, APB registers,
// row memory, window registers, controller and output register.
// Depends on gem_pkg and gem_root.
`default_nettype none

// Streaming 3x3 edge magnitude (Roberts, Prewitt or Sobel, chosen by the mode
// register) over 8-bit grey pixels in raster order. Assert tuser with the first
// pixel of a frame. For each pixel whose neighborhood is complete the block sends
// one request holding the rounded magnitude sqrt(h1^2 + h2^2), saturated at 255,
// and the column and row of the center pixel; border pixels produce nothing
// (but the bottom row does in Roberts mode). Rate: one pixel at a time. A pixel
// without a result passes through accept and row memory read with write-back; a
// pixel with a result through accept, memory read, squaring, 8 steps of the root
// unit and output load; the load waits while an untaken result is still held.
// The output register holds a finished result while the next pixel is taken.
// The two rows above the current one sit in one 1024 x 16 memory (upper, lower
// row per column); entries need no clearing, as normal raster input reads only
// entries written earlier in the same frame. Write registers only while idle.
// Registers (byte address): mode at 0x0, image_width at 0x4, image_height at 0x8;
// width and height are clamped to 3..1024 and 3..4096.
module gradient_edge_magnitude_top
    import gem_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] pixel
    input  wire logic        s_tuser,   // [0] frame_start
    // magnitude output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [7:0] edge_res, [17:8] out_x, [29:18] out_y
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  mode_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MODE:   mode_reg   <= pwdata[1:0];
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:   prdata = {30'd0, mode_reg};
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // effective frame size, clamped to the supported range
    logic [WID_W-1:0] wid;
    logic [HEI_W-1:0] hei;

    always_comb
    begin
        if (WID_W'(width_reg) < MIN_DIM_W)
            wid = MIN_DIM_W;
        else if (WID_W'(width_reg) > MAX_WID_VAL)
            wid = MAX_WID_VAL;
        else
            wid = WID_W'(width_reg);
        if (HEI_W'(height_reg) < MIN_DIM_H)
            hei = MIN_DIM_H;
        else if (HEI_W'(height_reg) > MAX_HEI_VAL)
            hei = MAX_HEI_VAL;
        else
            hei = HEI_W'(height_reg);
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    gem_state_t state_reg, state_next;
    logic       in_acc;
    logic       root_start;
    logic       load_out;
    logic       emit;
    root_stat_t root_stat;

    assign in_acc = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = emit ? ST_SQR : ST_IDLE;
            end
            ST_SQR:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_stat.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid || m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        root_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready   = 1'b1;
            ST_SQR:  root_start = 1'b1;
            ST_OUT:  load_out   = !m_tvalid || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Position counters: place the accepted pixel, then advance
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] x_cur;
    logic [ROW_W-1:0] y_cur;
    logic [COL_W-1:0] x_reg;
    logic [ROW_W-1:0] y_reg;
    logic [PIX_W-1:0] pix_reg;

    always_comb
    begin
        logic [WID_W-1:0] c0;
        logic [ROW_W-1:0] r0;
        logic [HEI_W-1:0] r_inc;
        logic [WID_W-1:0] c_inc;
        logic [HEI_W-1:0] r_inc2;

        c0    = s_tuser ? '0 : WID_W'(col_reg);
        r0    = s_tuser ? '0 : row_reg;
        r_inc = HEI_W'(r0) + HEI_W'(1);
        // column beyond a lowered width: wrap to the next row first
        if (c0 >= wid)
        begin
            x_cur = '0;
            y_cur = (r_inc >= hei) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            x_cur = c0[COL_W-1:0];
            y_cur = r0;
        end
        c_inc  = WID_W'(x_cur) + WID_W'(1);
        r_inc2 = HEI_W'(y_cur) + HEI_W'(1);
        if (c_inc >= wid)
        begin
            col_next = '0;
            row_next = (r_inc2 >= hei) ? '0 : r_inc2[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = y_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg   <= x_cur;
            y_reg   <= y_cur;
            pix_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Row memory: {row y-2, row y-1} per column; read on accept,
    // write back {old row y-1, new pixel} in the read cycle
    // ------------------------------------------------------------------
    logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;

    assign mem_we = (state_reg == ST_READ);
    assign top    = rd_data_reg[2*PIX_W-1:PIX_W];
    assign mid    = rd_data_reg[PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[x_reg] <= {mid, pix_reg};
        if (in_acc)
            rd_data_reg <= row_mem[x_cur];
    end

    // ------------------------------------------------------------------
    // Window: columns x-1 (0..2 = top, middle, bottom) and x-2 (3..5)
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (mem_we)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top;
            win_reg[1] <= mid;
            win_reg[2] <= pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Gradients, evaluated in the read cycle
    // ------------------------------------------------------------------
    logic signed [GRAD_W-1:0] h1, h2;
    logic signed [GRAD_W-1:0] h1_reg, h2_reg;
    logic [COL_W-1:0]         ox_reg;
    logic [ROW_W-1:0]         oy_reg;

    function automatic logic signed [GRAD_W-1:0] ext(input logic [PIX_W-1:0] p);
        return signed'(GRAD_W'(p));
    endfunction

    // the center pixel carries no weight in the Prewitt and Sobel operators
    always_comb
    begin
        logic signed [GRAD_W-1:0] lt, lm, lb, ct, cb, rt, rm, rb;
        logic                     dbl;

        ct = ext(win_reg[0]);
        cb = ext(win_reg[2]);
        lt = ext(win_reg[3]);
        lm = ext(win_reg[4]);
        lb = ext(win_reg[5]);
        rt = ext(top);
        rm = ext(mid);
        rb = ext(pix_reg);
        // mode 3 acts as Sobel
        dbl = (mode_reg != MODE_PREWITT);
        if (mode_reg == MODE_ROBERTS)
        begin
            h1   = cb - lm;
            h2   = cb - rm;
            emit = (x_reg >= COL_W'(2)) && (y_reg >= ROW_W'(1));
        end
        else
        begin
            h1   = (lb + (dbl ? (cb <<< 1) : cb) + rb) - (lt + (dbl ? (ct <<< 1) : ct) + rt);
            h2   = (rt + (dbl ? (rm <<< 1) : rm) + rb) - (lt + (dbl ? (lm <<< 1) : lm) + lb);
            emit = (x_reg >= COL_W'(2)) && (y_reg >= ROW_W'(2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            h1_reg <= h1;
            h2_reg <= h2;
            ox_reg <= x_reg - COL_W'(1);
            oy_reg <= (mode_reg == MODE_ROBERTS) ? y_reg : (y_reg - ROW_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Sum of squares and root
    // ------------------------------------------------------------------
    logic signed [2*GRAD_W-1:0] sq1, sq2;
    logic [SUM_W-1:0]           sum_sq;

    assign sq1    = h1_reg * h1_reg;
    assign sq2    = h2_reg * h2_reg;
    assign sum_sq = SUM_W'(sq1[SUM_W-2:0]) + SUM_W'(sq2[SUM_W-2:0]);

    gem_root u_root
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .sum   (sum_sq),
        .stat  (root_stat)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic             m_valid_reg;
    logic [PIX_W-1:0] edge_reg;
    logic [COL_W-1:0] out_x_reg;
    logic [ROW_W-1:0] out_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            edge_reg  <= root_stat.value;
            out_x_reg <= ox_reg;
            out_y_reg <= oy_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_y_reg, out_x_reg, edge_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the root unit runs exactly one step per result bit
    a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_ROOT) |-> ##(PIX_W) (state_reg == ST_OUT))
        else $error("root unit did not finish in the expected number of steps");

    // an accepted pixel always reaches the memory read cycle next
    a_acc_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_READ))
        else $error("accepted pixel did not proceed to the memory read");

    // a new result only appears from the output load state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("output valid raised outside the output load");

    // no pixel is accepted while a magnitude is still being computed
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQR || state_reg == ST_ROOT || state_reg == ST_OUT) |-> !s_tready)
        else $error("pixel accepted during a computation");

endmodule

`default_nettype wire
